// ----- hdl/swat_pkg.sv -----
`default_nettype none

package swat_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);

    localparam int ADDR_W  = 32;
    localparam int WIDE_W  = 33;
    localparam int SLOT_W  = 4;
    localparam int NUM_W   = 5;
    localparam int SIU_W   = 5;
    localparam int CFG_W   = 32;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_V2F   = 2'd1,
        REQ_F2V   = 2'd2,
        REQ_CLASS = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CODE = 2'd1,
        KIND_DATA = 2'd2
    } t_kind;

    typedef enum logic {
        CFG_SECTIONS_IN_USE = 1'b0,
        CFG_FILE_LENGTH     = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] address;
        logic [SLOT_W-1:0] entry_index;
        logic [ADDR_W-1:0] entry_virtual_base;
        logic [ADDR_W-1:0] entry_file_offset;
        logic [ADDR_W-1:0] entry_size;
        logic              entry_is_code;
    } t_in_word;

    typedef struct packed {
        logic [WIDE_W-1:0] translated;
        logic              hit;
        logic [WIDE_W-1:0] region_start;
        logic [WIDE_W-1:0] region_end;
        logic [1:0]        region_kind;
        logic [NUM_W-1:0]  section_number;
    } t_out_word;

    typedef struct packed {
        logic [ADDR_W-1:0] virtual_base;
        logic [ADDR_W-1:0] file_offset;
        logic [ADDR_W-1:0] length;
        logic              code;
    } t_entry;

    // compare results of one window check
    typedef struct packed {
        logic [WIDE_W-1:0] lim;
        logic [ADDR_W-1:0] diff;
        logic              ge_lo;
        logic              le_lim;
        logic              lt_lim;
        logic              ge_start;
    } t_alu_flags;

endpackage

`default_nettype wire

// ----- hdl/swat_table.sv -----
`default_nettype none

module swat_table
    import swat_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [SLOT_W-1:0] i_wr_slot,
    input  wire t_entry            i_wr_entry,
    input  wire logic [IDX_W-1:0]  i_rd_idx,
    output t_entry                 o_rd_entry
);

    t_entry r_mem [MAX_SECTIONS];
    t_entry r_rd;

    // slots beyond the table depth are dropped
    always_ff @(posedge i_clk) begin
        if (i_we && (32'(i_wr_slot) < MAX_SECTIONS)) begin
            r_mem[IDX_W'(i_wr_slot)] <= i_wr_entry;
        end
        r_rd <= r_mem[i_rd_idx];
    end

    assign o_rd_entry = r_rd;

endmodule

`default_nettype wire

// ----- hdl/swat_alu.sv -----
`default_nettype none

module swat_alu
    import swat_pkg::*;
(
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [ADDR_W-1:0] i_lo,
    input  wire logic [ADDR_W-1:0] i_len,
    input  wire logic [WIDE_W-1:0] i_start,
    output t_alu_flags             o_flags
);

    logic [WIDE_W-1:0] w_addr;
    logic [WIDE_W-1:0] w_lim;

    assign w_addr = {1'b0, i_addr};
    assign w_lim  = {1'b0, i_lo} + {1'b0, i_len};

    always_comb begin
        o_flags.lim      = w_lim;
        o_flags.diff     = i_addr - i_lo;
        o_flags.ge_lo    = (i_addr >= i_lo);
        o_flags.le_lim   = (w_addr <= w_lim);
        o_flags.lt_lim   = (w_addr < w_lim);
        o_flags.ge_start = (w_addr >= i_start);
    end

endmodule

`default_nettype wire

// ----- hdl/section_window_address_translator_unit.sv -----
`default_nettype none

// Section window address translator. A table of section windows (virtual
// base, file offset, size, code flag) is loaded by write words and scanned in
// order by virtual-to-file, file-to-virtual and region query words; the first
// window that holds the address wins, with an inclusive end bound for
// translation and an exclusive one for region queries. Only the first
// sections_in_use entries are scanned (capped at the table depth). A query
// scan ends early on a hit or a gap. The table's single registered read
// port feeds one shared add/compare unit, one entry per cycle; a translation
// hit takes a final add step, and each finished word is then handed to the
// output register. A word held in the output register does not block the
// next input word; a second finished word waits in the sequencer, with the
// input not ready, until the output register frees. Entries that were never
// written read as garbage; the user must write configuration registers only
// while the block is idle, which the block itself does not enforce.
module section_window_address_translator_unit
    import swat_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,

    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_word,

    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_word
);

    // configuration
    logic [SIU_W-1:0]  r_siu;
    logic [ADDR_W-1:0] r_flen;

    // sequencer
    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [WIDE_W-1:0] r_start, n_start;
    logic [ADDR_W-1:0] r_to, n_to;
    logic [ADDR_W-1:0] r_diff, n_diff;
    t_out_word         r_res, n_res;

    // output register
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    logic              w_in_acc;
    logic              w_out_free;
    logic [CNT_W-1:0]  w_scan_n;
    logic              w_last;
    logic [IDX_W-1:0]  w_rd_idx;
    t_entry            w_entry;
    t_entry            w_wr_entry;
    logic [ADDR_W-1:0] w_lo;
    t_alu_flags        w_flags;

    // input side is open only between words
    assign o_in_ready = (r_state == S_IDLE);

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_scan_n   = (32'(r_siu) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS)
                                                    : CNT_W'(r_siu);
    assign w_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == w_scan_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_siu  <= '0;
            r_flen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SECTIONS_IN_USE: r_siu  <= i_cfg_data[SIU_W-1:0];
                CFG_FILE_LENGTH:     r_flen <= i_cfg_data[ADDR_W-1:0];
                default:             r_siu  <= r_siu;
            endcase
        end
    end

    // entry i sits on the read port in the scan cycle for i; fetch the next
    assign w_rd_idx = (r_state == S_SCAN) ? (r_idx + IDX_W'(1)) : '0;

    always_comb begin
        w_wr_entry.virtual_base = i_in_word.entry_virtual_base;
        w_wr_entry.file_offset  = i_in_word.entry_file_offset;
        w_wr_entry.length       = i_in_word.entry_size;
        w_wr_entry.code         = i_in_word.entry_is_code;
    end

    swat_table u_table (
        .i_clk      (i_clk),
        .i_we       (w_in_acc && (t_req'(i_in_word.req_type) == REQ_WRITE)),
        .i_wr_slot  (i_in_word.entry_index),
        .i_wr_entry (w_wr_entry),
        .i_rd_idx   (w_rd_idx),
        .o_rd_entry (w_entry)
    );

    // virtual-to-file matches on the virtual base, everything else on offset
    assign w_lo = (r_req == REQ_V2F) ? w_entry.virtual_base : w_entry.file_offset;

    swat_alu u_alu (
        .i_addr  (r_addr),
        .i_lo    (w_lo),
        .i_len   (w_entry.length),
        .i_start (r_start),
        .o_flags (w_flags)
    );

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_start     = r_start;
        n_to        = r_to;
        n_diff      = r_diff;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_req   = t_req'(i_in_word.req_type);
                    n_addr  = i_in_word.address;
                    n_idx   = '0;
                    n_start = '0;
                    n_res   = '0;
                    if (t_req'(i_in_word.req_type) == REQ_CLASS) begin
                        n_res.region_end = {1'b0, r_flen};
                    end
                    if (t_req'(i_in_word.req_type) == REQ_WRITE || w_scan_n == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                n_idx = r_idx + IDX_W'(1);
                if (r_req == REQ_CLASS) begin
                    if (w_flags.ge_start && !w_flags.ge_lo) begin
                        // gap ahead of this section
                        n_res.region_start = r_start;
                        n_res.region_end   = {1'b0, w_entry.file_offset};
                        n_state            = S_DONE;
                    end else if (w_flags.ge_lo && w_flags.lt_lim) begin
                        n_res.hit            = 1'b1;
                        n_res.region_start   = {1'b0, w_entry.file_offset};
                        n_res.region_end     = w_flags.lim;
                        n_res.region_kind    = w_entry.code ? KIND_CODE : KIND_DATA;
                        n_res.section_number = NUM_W'(r_idx) + NUM_W'(1);
                        n_state              = S_DONE;
                    end else begin
                        n_start = w_flags.lim;
                        if (w_last) begin
                            // trailing region after the last section
                            n_res.region_start = w_flags.lim;
                            n_state            = S_DONE;
                        end
                    end
                end else begin
                    if (w_flags.ge_lo && w_flags.le_lim) begin
                        n_to    = (r_req == REQ_V2F) ? w_entry.file_offset
                                                     : w_entry.virtual_base;
                        n_diff  = w_flags.diff;
                        n_state = S_FINISH;
                    end else if (w_last) begin
                        n_state = S_DONE;
                    end
                end
            end

            S_FINISH: begin
                n_res.translated = {1'b0, r_to} + {1'b0, r_diff};
                n_res.hit        = 1'b1;
                n_state          = S_DONE;
            end

            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_addr  <= n_addr;
        r_idx   <= n_idx;
        r_start <= n_start;
        r_to    <= n_to;
        r_diff  <= n_diff;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // the scan never runs past the scanned count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_idx) < w_scan_n))
        else $error("scan index beyond section count");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("ready held high after accept");

    // a section kind only comes with a hit and a section number
    a_kind_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.region_kind != KIND_NONE)) |->
        (o_out_word.hit && (o_out_word.section_number != '0)))
        else $error("region kind without matching section");

    // a finished word is never dropped while the output is stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result left before output slot freed");

endmodule

`default_nettype wire
